// File: design/mvm_pkg.sv
// Shared widths, codes and defaults of the matrix-vector product engine.
`timescale 1ns / 1ps

package mvm_pkg;

  // Defaults of the store sizes
  localparam int DEF_MAX_ROWS = 64;
  localparam int DEF_MAX_COLS = 64;

  // Field widths
  localparam int ACT_W  = 2;
  localparam int IDX_W  = 6;
  localparam int SIZE_W = 7;
  localparam int VAL_W  = 32;
  localparam int RES_W  = 64;
  // Holds up to 511 full-scale products without wrapping
  localparam int ACC_W  = 72;

  // Configuration port
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_IN_USE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_IN_USE = 1'b1;

  // Saturation limits of a Q32.32 result
  localparam logic signed [RES_W-1:0] RES_MAX = {1'b0, {(RES_W-1){1'b1}}};
  localparam logic signed [RES_W-1:0] RES_MIN = {1'b1, {(RES_W-1){1'b0}}};

  // Command codes
  typedef enum logic [ACT_W-1:0] {
    ACT_WRITE_MATRIX = 2'd0,
    ACT_WRITE_VECTOR = 2'd1,
    ACT_COMPUTE      = 2'd2
  } action_t;

endpackage

// File: design/mvm_channels.sv
// Command and result channel interfaces of the matrix-vector product engine.
`timescale 1ns / 1ps

interface mvm_cmd_if import mvm_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [ACT_W-1:0]        action;
  logic [IDX_W-1:0]        row_index;
  logic [IDX_W-1:0]        col_index;
  logic signed [VAL_W-1:0] entry_value;

  modport source (output valid, action, row_index, col_index, entry_value, input ready);
  modport sink   (input valid, action, row_index, col_index, entry_value, output ready);
endinterface

interface mvm_res_if import mvm_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [IDX_W-1:0]        result_row;
  logic signed [RES_W-1:0] result_value;
  logic                    saturated;
  logic                    last;

  modport source (output valid, result_row, result_value, saturated, last, input ready);
  modport sink   (input valid, result_row, result_value, saturated, last, output ready);
endinterface

// File: design/matrix_vector_multiply.sv
// Channel     | Dir | Payload
// ------------+-----+---------------------------------------------------------
// cmd         | in  | action, row_index, col_index, entry_value
// res         | out | result_row, result_value, saturated, last
// cfg_*       | in  | cfg_we, cfg_index, cfg_data (rows_in_use, cols_in_use)
//
// A compute transaction issues one matrix read per cycle, unless the pipeline is
// stalled, from the cycle after it is accepted; each row result passes through the
// read data and product registers into the output register after its last read.
// The single read port of the matrix memory sets that pace (one MAC a cycle).
// Reset clears control state only; both stores are undefined until written.
// A stalled result holds the whole read/multiply/accumulate pipeline as a row ends.
`timescale 1ns / 1ps

module matrix_vector_multiply import mvm_pkg::*; #(
  parameter int MAX_ROWS = DEF_MAX_ROWS,
  parameter int MAX_COLS = DEF_MAX_COLS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SIZE_W-1:0]    cfg_data,
  mvm_cmd_if.sink              cmd,
  mvm_res_if.source            res
);

  localparam int ROW_AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COL_AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int MAT_AW = ROW_AW + COL_AW;

  typedef enum logic {ST_IDLE, ST_RUN} state_t;

  // Size registers
  logic [SIZE_W-1:0] rows_in_use;
  logic [SIZE_W-1:0] cols_in_use;
  logic [SIZE_W-1:0] rows_eff;
  logic [SIZE_W-1:0] cols_eff;
  logic [ROW_AW-1:0] row_last;
  logic [COL_AW-1:0] col_last;

  // Sequencer
  state_t            state;
  logic [ROW_AW-1:0] row_cnt;
  logic [COL_AW-1:0] col_cnt;
  logic              issue;
  logic              adv;
  logic              cmd_fire;

  // Memories
  logic [VAL_W-1:0]  mat_mem [2**MAT_AW];
  logic [VAL_W-1:0]  vec_mem [2**COL_AW];
  logic              mat_we;
  logic              vec_we;
  logic [MAT_AW-1:0] mat_wr_addr;
  logic [COL_AW-1:0] vec_wr_addr;

  // Pipeline
  logic                    s1_valid;
  logic                    s1_lastcol;
  logic                    s1_lastrow;
  logic [ROW_AW-1:0]       s1_row;
  logic signed [VAL_W-1:0] mat_q;
  logic signed [VAL_W-1:0] vec_q;
  logic                    s2_valid;
  logic                    s2_lastcol;
  logic                    s2_lastrow;
  logic [ROW_AW-1:0]       s2_row;
  logic signed [RES_W-1:0] prod;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] acc_sum;
  logic [ACC_W-RES_W:0]    acc_top;
  logic                    sum_fits;

  // Output register
  logic                    res_valid;
  logic [IDX_W-1:0]        res_row;
  logic signed [RES_W-1:0] res_value;
  logic                    res_sat;
  logic                    res_last;

  // Take configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use <= SIZE_W'(1);
      cols_in_use <= SIZE_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROWS_IN_USE: rows_in_use <= cfg_data;
        REG_COLS_IN_USE: cols_in_use <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp sizes into 1..MAX
  always_comb begin
    if (rows_in_use == '0) begin
      rows_eff = SIZE_W'(1);
    end else if (int'(rows_in_use) > MAX_ROWS) begin
      rows_eff = SIZE_W'(MAX_ROWS);
    end else begin
      rows_eff = rows_in_use;
    end
    if (cols_in_use == '0) begin
      cols_eff = SIZE_W'(1);
    end else if (int'(cols_in_use) > MAX_COLS) begin
      cols_eff = SIZE_W'(MAX_COLS);
    end else begin
      cols_eff = cols_in_use;
    end
  end

  assign row_last = ROW_AW'(rows_eff - SIZE_W'(1));
  assign col_last = COL_AW'(cols_eff - SIZE_W'(1));

  // Handshake and stall
  assign cmd.ready = (state == ST_IDLE);
  assign cmd_fire  = cmd.valid && cmd.ready;
  assign issue     = (state == ST_RUN);
  assign adv       = !(s2_valid && s2_lastcol && res_valid && !res.ready);

  // Store writes, dropped when the index lies beyond the sizes in use
  assign mat_we = cmd_fire && (cmd.action == ACT_WRITE_MATRIX) &&
                  (SIZE_W'(cmd.row_index) < rows_eff) &&
                  (SIZE_W'(cmd.col_index) < cols_eff);
  assign vec_we = cmd_fire && (cmd.action == ACT_WRITE_VECTOR) &&
                  (SIZE_W'(cmd.col_index) < cols_eff);
  assign mat_wr_addr = {ROW_AW'(cmd.row_index), COL_AW'(cmd.col_index)};
  assign vec_wr_addr = COL_AW'(cmd.col_index);

  // Sequence the row and column walk of a compute transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      row_cnt <= '0;
      col_cnt <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (cmd_fire && (cmd.action == ACT_COMPUTE)) begin
            state   <= ST_RUN;
            row_cnt <= '0;
            col_cnt <= '0;
          end
        end
        ST_RUN: begin
          if (adv) begin
            if (col_cnt == col_last) begin
              col_cnt <= '0;
              if (row_cnt == row_last) begin
                state <= ST_IDLE;
              end else begin
                row_cnt <= row_cnt + ROW_AW'(1);
              end
            end else begin
              col_cnt <= col_cnt + COL_AW'(1);
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Matrix memory: writes only while idle, reads only while walking
  always_ff @(posedge clk) begin
    if (mat_we) begin
      mat_mem[mat_wr_addr] <= cmd.entry_value;
    end else if (issue && adv) begin
      mat_q <= mat_mem[{row_cnt, col_cnt}];
    end
  end

  // Vector memory
  always_ff @(posedge clk) begin
    if (vec_we) begin
      vec_mem[vec_wr_addr] <= cmd.entry_value;
    end else if (issue && adv) begin
      vec_q <= vec_mem[col_cnt];
    end
  end

  // Advance pipeline control tags
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= issue;
      s2_valid <= s1_valid;
    end
  end

  // Advance pipeline payload: tags, then the product
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_lastcol <= (col_cnt == col_last);
      s1_lastrow <= (row_cnt == row_last);
      s1_row     <= row_cnt;
      s2_lastcol <= s1_lastcol;
      s2_lastrow <= s1_lastrow;
      s2_row     <= s1_row;
      prod       <= mat_q * vec_q;
    end
  end

  // Accumulate; the top bits must all match the sign to fit in Q32.32
  assign acc_sum  = acc + ACC_W'(prod);
  assign acc_top  = acc_sum[ACC_W-1:RES_W-1];
  assign sum_fits = (&acc_top) || !(|acc_top);

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (adv && s2_valid) begin
      acc <= s2_lastcol ? '0 : acc_sum;
    end
  end

  // Output register: load at the end of a row, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (adv && s2_valid && s2_lastcol) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s2_valid && s2_lastcol) begin
      res_row   <= IDX_W'(s2_row);
      res_sat   <= !sum_fits;
      res_last  <= s2_lastrow;
      if (sum_fits) begin
        res_value <= acc_sum[RES_W-1:0];
      end else begin
        res_value <= acc_sum[ACC_W-1] ? RES_MIN : RES_MAX;
      end
    end
  end

  assign res.valid        = res_valid;
  assign res.result_row   = res_row;
  assign res.result_value = res_value;
  assign res.saturated    = res_sat;
  assign res.last         = res_last;

  // A finished row with a free output slot lands there next cycle
  a_row_lands: assert property (@(posedge clk) disable iff (rst)
    (s2_valid && s2_lastcol && !res_valid) |=> res_valid)
    else $error("finished row did not reach the output register");

  // Walk counters stay within the sizes in use
  a_walk_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> (col_cnt <= col_last) && (row_cnt <= row_last))
    else $error("walk counter beyond size in use");

  // The marked result is the final row
  a_last_row: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.last) |-> (res.result_row == IDX_W'(row_last)))
    else $error("last mark on a row other than the final one");

  // A clamped result sits at one of the two limits
  a_sat_value: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.saturated) |->
      ((res.result_value == RES_MAX) || (res.result_value == RES_MIN)))
    else $error("saturated result not at a limit");

endmodule

// File: verif/matrix_vector_multiply_checker.sv
// Result checker of the matrix-vector product engine: it mirrors the stores and checks each row.
`timescale 1ns / 1ps

module matrix_vector_multiply_checker import mvm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SIZE_W-1:0]    cfg_data,
  mvm_cmd_if                   cmd,
  mvm_res_if                   res,
  output int                   errors,
  output int                   outstanding
);

  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [IDX_W-1:0]        row;
    logic signed [RES_W-1:0] value;
    logic                    sat;
    logic                    last;
  } row_result_t;

  // Mirror of the stores and of the size registers
  logic signed [VAL_W-1:0] mat_mem [DEF_MAX_ROWS][DEF_MAX_COLS];
  logic signed [VAL_W-1:0] vec_mem [DEF_MAX_COLS];
  logic [SIZE_W-1:0]       rows_raw;
  logic [SIZE_W-1:0]       cols_raw;

  // Row results still owed by the block, oldest first
  row_result_t row_results_q[$];

  // Zero acts as one, anything past the store acts as the full store
  function automatic int size_used(input logic [SIZE_W-1:0] raw, input int limit);
    if (raw == '0) return 1;
    if (int'(raw) > limit) return limit;
    return int'(raw);
  endfunction

  // Exact dot product per row, clamped to Q32.32
  task automatic predict_rows(input int nr, input int nc);
    logic signed [127:0]     acc;
    logic signed [RES_W-1:0] lhs;
    logic signed [RES_W-1:0] rhs;
    row_result_t             item;
    for (int r = 0; r < nr; r++) begin
      acc = '0;
      for (int c = 0; c < nc; c++) begin
        lhs = mat_mem[r][c];
        rhs = vec_mem[c];
        acc = acc + lhs * rhs;
      end
      item.row  = IDX_W'(r);
      item.sat  = 1'b1;
      item.last = (r == nr - 1);
      if (acc > RES_MAX) begin
        item.value = RES_MAX;
      end else if (acc < RES_MIN) begin
        item.value = RES_MIN;
      end else begin
        item.value = acc[RES_W-1:0];
        item.sat   = 1'b0;
      end
      row_results_q.push_back(item);
    end
  endtask

  always @(posedge clk) begin : watch
    row_result_t want;
    if (rst) begin
      rows_raw = SIZE_W'(1);
      cols_raw = SIZE_W'(1);
      row_results_q.delete();
      outstanding <= 0;
    end else begin
      // Check a result transaction against the oldest expectation
      if (res.valid && res.ready) begin
        if (row_results_q.size() == 0) begin
          if (errors < REPORT_LIMIT)
            $display("unexpected result: row %0d value %h sat %0b last %0b",
                     res.result_row, res.result_value, res.saturated, res.last);
          errors++;
        end else begin
          want = row_results_q.pop_front();
          if (res.result_row !== want.row || res.result_value !== want.value ||
              res.saturated !== want.sat || res.last !== want.last) begin
            if (errors < REPORT_LIMIT)
              $display("mismatch (exp/got): row %0d/%0d value %h/%h sat %0b/%0b last %0b/%0b",
                       want.row, res.result_row, want.value, res.result_value,
                       want.sat, res.saturated, want.last, res.last);
            errors++;
          end
        end
      end

      // Track register writes
      if (cfg_we) begin
        if (cfg_index == REG_ROWS_IN_USE) rows_raw = cfg_data;
        else if (cfg_index == REG_COLS_IN_USE) cols_raw = cfg_data;
      end

      // Apply a command transaction
      if (cmd.valid && cmd.ready) begin
        case (cmd.action)
          ACT_WRITE_MATRIX: begin
            if (cmd.row_index < size_used(rows_raw, DEF_MAX_ROWS) &&
                cmd.col_index < size_used(cols_raw, DEF_MAX_COLS))
              mat_mem[cmd.row_index][cmd.col_index] = cmd.entry_value;
          end
          ACT_WRITE_VECTOR: begin
            if (cmd.col_index < size_used(cols_raw, DEF_MAX_COLS))
              vec_mem[cmd.col_index] = cmd.entry_value;
          end
          ACT_COMPUTE: begin
            predict_rows(size_used(rows_raw, DEF_MAX_ROWS),
                         size_used(cols_raw, DEF_MAX_COLS));
          end
          default: ;
        endcase
      end

      outstanding <= row_results_q.size();
    end
  end

endmodule

// File: verif/matrix_vector_multiply_tb.sv
// Testbench top of the matrix-vector product engine: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module matrix_vector_multiply_tb;
  import mvm_pkg::*;

  localparam int WATCHDOG_LIMIT   = 20000;
  localparam int HOLD_CYCLES      = 300;
  localparam int SETTLE_CYCLES    = 8;
  localparam int END_CYCLES       = 10;
  localparam int RANDOM_PER_PHASE = 14;
  localparam int NUM_PHASES       = 8;

  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
  localparam logic [VAL_W-1:0] Q_MAX      = 32'h7FFF_FFFF;
  localparam logic [VAL_W-1:0] Q_MIN      = 32'h8000_0000;

  // Raw register values per phase, extremes and out-of-range values included
  localparam int PHASE_ROWS [NUM_PHASES] = '{3, 0, 127, 5, 64, 2, 16, 1};
  localparam int PHASE_COLS [NUM_PHASES] = '{4, 127, 0, 7, 2, 3, 5, 64};
  // Idle mix cycles through: none, sender, receiver, both
  localparam int SEND_IDLE  [4] = '{0, 76, 0, 17};
  localparam int RECV_STALL [4] = '{0, 0, 76, 17};

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [SIZE_W-1:0]    cfg_data;

  mvm_cmd_if cmd ();
  mvm_res_if res ();

  int errors;
  int outstanding;
  int send_idle_pct;
  int stall_pct;
  int holds_asked;
  int holds_served;
  int hold_left;
  int quiet_cycles;
  int rows_now;
  int cols_now;

  // Entries written so far, so that a compute never reads an unwritten one
  bit mat_written [DEF_MAX_ROWS][DEF_MAX_COLS];
  bit vec_written [DEF_MAX_COLS];

  matrix_vector_multiply u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .res       (res)
  );

  matrix_vector_multiply_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .cmd         (cmd),
    .res         (res),
    .errors      (errors),
    .outstanding (outstanding)
  );

  always #5 clk = ~clk;

  // Receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      res.ready <= 1'b0;
    end else if (holds_served < holds_asked) begin
      holds_served++;
      hold_left = HOLD_CYCLES - 1;
      res.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      res.ready <= 1'b0;
    end else begin
      res.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (cmd.valid && cmd.ready) || (res.valid && res.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("matrix_vector_multiply_tb NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic int size_used(input int raw, input int limit);
    if (raw == 0) return 1;
    if (raw > limit) return limit;
    return raw;
  endfunction

  // Bias toward the extremes so that sums saturate now and then
  function automatic logic [VAL_W-1:0] rand_entry();
    case ($urandom_range(0, 9))
      0: return Q_MIN;
      1: return Q_MAX;
      2: return '0;
      3: return (VAL_W'($urandom_range(0, 8)) - VAL_W'(4)) << 16;
      default: return $urandom();
    endcase
  endfunction

  // Offer one command transaction and hold it until accepted
  task automatic send_item(input logic [ACT_W-1:0] act, input logic [IDX_W-1:0] row,
                           input logic [IDX_W-1:0] col, input logic [VAL_W-1:0] val);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      cmd.valid <= 1'b0;
      @(posedge clk);
    end
    cmd.valid       <= 1'b1;
    cmd.action      <= act;
    cmd.row_index   <= row;
    cmd.col_index   <= col;
    cmd.entry_value <= val;
    do @(posedge clk); while (!cmd.ready);
    if (act == ACT_WRITE_MATRIX && row < rows_now && col < cols_now)
      mat_written[row][col] = 1'b1;
    if (act == ACT_WRITE_VECTOR && col < cols_now)
      vec_written[col] = 1'b1;
  endtask

  // Drop valid and wait until every row result has come back
  task automatic drain();
    cmd.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Write both size registers while the block is idle
  task automatic apply_sizes(input int rows_raw, input int cols_raw);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_ROWS_IN_USE;
    cfg_data  <= SIZE_W'(rows_raw);
    @(posedge clk);
    cfg_index <= REG_COLS_IN_USE;
    cfg_data  <= SIZE_W'(cols_raw);
    @(posedge clk);
    cfg_we   <= 1'b0;
    rows_now = size_used(rows_raw, DEF_MAX_ROWS);
    cols_now = size_used(cols_raw, DEF_MAX_COLS);
  endtask

  // Write every entry in use that was never written
  task automatic fill_unwritten();
    for (int r = 0; r < rows_now; r++)
      for (int c = 0; c < cols_now; c++)
        if (!mat_written[r][c])
          send_item(ACT_WRITE_MATRIX, IDX_W'(r), IDX_W'(c), rand_entry());
    for (int c = 0; c < cols_now; c++)
      if (!vec_written[c])
        send_item(ACT_WRITE_VECTOR, '0, IDX_W'(c), rand_entry());
  endtask

  // Mostly in-range updates and computes, some noise and pauses
  task automatic run_random(input int count);
    int               done_items;
    int               pick;
    logic [ACT_W-1:0] act;
    done_items = 0;
    while (done_items < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        send_item(ACT_WRITE_MATRIX, IDX_W'($urandom_range(0, rows_now - 1)),
                  IDX_W'($urandom_range(0, cols_now - 1)), rand_entry());
        done_items++;
      end else if (pick < 55) begin
        send_item(ACT_WRITE_VECTOR, IDX_W'($urandom()),
                  IDX_W'($urandom_range(0, cols_now - 1)), rand_entry());
        done_items++;
      end else if (pick < 78) begin
        send_item(ACT_COMPUTE, IDX_W'($urandom()), IDX_W'($urandom()), $urandom());
        done_items++;
      end else if (pick < 95) begin
        case ($urandom_range(0, 2))
          0: act = ACT_WRITE_MATRIX;
          1: act = ACT_WRITE_VECTOR;
          default: act = ACT_UNUSED;
        endcase
        send_item(act, IDX_W'($urandom()), IDX_W'($urandom()), rand_entry());
      end else begin
        drain();
      end
    end
  endtask

  initial begin
    clk             = 1'b0;
    rst             = 1'b1;
    cfg_we          = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    cmd.valid       = 1'b0;
    cmd.action      = '0;
    cmd.row_index   = '0;
    cmd.col_index   = '0;
    cmd.entry_value = '0;
    send_idle_pct   = 0;
    stall_pct       = 0;
    holds_asked     = 0;
    rows_now        = 1;
    cols_now        = 1;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Sizes after reset are one by one; writes past them are dropped
    send_item(ACT_WRITE_MATRIX, 6'd0, 6'd0, Q_MAX);
    send_item(ACT_WRITE_VECTOR, 6'd0, 6'd0, Q_MAX);
    send_item(ACT_COMPUTE, 6'd0, 6'd0, '0);
    send_item(ACT_WRITE_MATRIX, 6'd1, 6'd0, Q_MIN);
    send_item(ACT_WRITE_MATRIX, 6'd0, 6'd63, Q_MIN);
    send_item(ACT_WRITE_VECTOR, 6'd63, 6'd63, '0);
    send_item(ACT_UNUSED, 6'd63, 6'd63, 32'hFFFF_FFFF);
    send_item(ACT_COMPUTE, 6'd63, 6'd63, 32'hFFFF_FFFF);

    // Two rows by three columns: row 0 overflows high, row 1 low
    apply_sizes(2, 3);
    for (int c = 0; c < 3; c++) begin
      send_item(ACT_WRITE_MATRIX, 6'd0, IDX_W'(c), Q_MIN);
      send_item(ACT_WRITE_MATRIX, 6'd1, IDX_W'(c), Q_MAX);
      send_item(ACT_WRITE_VECTOR, 6'd0, IDX_W'(c), Q_MIN);
    end
    send_item(ACT_COMPUTE, 6'd0, 6'd0, '0);
    send_item(ACT_WRITE_MATRIX, 6'd0, 6'd0, '0);
    send_item(ACT_COMPUTE, 6'd0, 6'd0, '0);

    // Random phases over several sizes and idle mixes
    for (int p = 0; p < NUM_PHASES; p++) begin
      apply_sizes(PHASE_ROWS[p], PHASE_COLS[p]);
      send_idle_pct = SEND_IDLE[p % 4];
      stall_pct     = RECV_STALL[p % 4];
      fill_unwritten();
      // Long receiver hold-off while the sender keeps offering
      if (p == 0) holds_asked++;
      run_random(RANDOM_PER_PHASE);
    end

    drain();
    repeat (END_CYCLES) @(posedge clk);
    if (errors == 0 && outstanding == 0) begin
      $display("matrix_vector_multiply_tb OK");
    end else begin
      $display("matrix_vector_multiply_tb NOT OK");
    end
    $finish;
  end

endmodule

// File: matrix_vector_multiply.f
design/mvm_pkg.sv
design/mvm_channels.sv
design/matrix_vector_multiply.sv
verif/matrix_vector_multiply_checker.sv
verif/matrix_vector_multiply_tb.sv
